/* rtl/core/jimw_pkg.sv */
package jimw_pkg;

  localparam int EXP_CELLS  = 14;
  localparam int DIV_CELLS  = 21;
  localparam int SQRT_CELLS = 16;

  localparam logic [31:0] Q_ONE  = 32'd1048576;
  localparam logic [31:0] Q_HALF = 32'd524288;

  localparam logic REG_WINDOW_LOW  = 1'b0;
  localparam logic REG_WINDOW_HIGH = 1'b1;

  localparam logic [15:0] WINDOW_LOW_RST  = 16'd400;
  localparam logic [15:0] WINDOW_HIGH_RST = 16'd560;

  typedef struct packed {
    logic [15:0] pt;
    logic [15:0] energy;
    logic        sat;
    logic        pos;
  } tag_t;

  // e^(2^k/1024) in q20
  function automatic logic [31:0] exp_tab(input int k);
    logic [31:0] v;
    v = 32'd0;
    unique case (k)
      0:  v = 32'd1049601;
      1:  v = 32'd1050626;
      2:  v = 32'd1052680;
      3:  v = 32'd1056800;
      4:  v = 32'd1065089;
      5:  v = 32'd1081861;
      6:  v = 32'd1116203;
      7:  v = 32'd1188192;
      8:  v = 32'd1346398;
      9:  v = 32'd1728810;
      10: v = 32'd2850325;
      11: v = 32'd7747987;
      12: v = 32'd57250310;
      13: v = 32'd3125760002;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/jimw_exp_cell.sv */
module jimw_exp_cell
  import jimw_pkg::*;
#(
  parameter int K = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  tag_t        in_tag,
  input  logic [13:0] in_mag,
  input  logic [31:0] in_acc,
  output logic        out_valid,
  output tag_t        out_tag,
  output logic [13:0] out_mag,
  output logic [31:0] out_acc
);

  logic [63:0] prod;
  logic [63:0] rnd;
  logic [31:0] acc_nxt;
  logic        valid_r;
  tag_t        tag_r;
  logic [13:0] mag_r;
  logic [31:0] acc_r;

  always_comb begin
    prod    = 64'(in_acc) * 64'(exp_tab(K));
    rnd     = prod + 64'(Q_HALF);
    acc_nxt = in_mag[K] ? rnd[51:20] : in_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    tag_r <= in_tag;
    mag_r <= in_mag;
    acc_r <= acc_nxt;
  end

  assign out_valid = valid_r;
  assign out_tag   = tag_r;
  assign out_mag   = mag_r;
  assign out_acc   = acc_r;

endmodule

/* rtl/core/jimw_div_cell.sv */
module jimw_div_cell
  import jimw_pkg::*;
#(
  parameter int I = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  tag_t        in_tag,
  input  logic [31:0] in_ep,
  input  logic [41:0] in_rem,
  input  logic [20:0] in_q,
  output logic        out_valid,
  output tag_t        out_tag,
  output logic [31:0] out_ep,
  output logic [41:0] out_rem,
  output logic [20:0] out_q
);

  logic [52:0] sh;
  logic [52:0] diff;
  logic        ge;
  logic [41:0] rem_nxt;
  logic [20:0] q_nxt;
  logic        valid_r;
  tag_t        tag_r;
  logic [31:0] ep_r;
  logic [41:0] rem_r;
  logic [20:0] q_r;

  // one quotient bit per cell
  always_comb begin
    sh      = 53'(in_ep) << I;
    ge      = {11'b0, in_rem} >= sh;
    diff    = {11'b0, in_rem} - sh;
    rem_nxt = ge ? diff[41:0] : in_rem;
    q_nxt   = in_q;
    q_nxt[I] = ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    tag_r <= in_tag;
    ep_r  <= in_ep;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign out_valid = valid_r;
  assign out_tag   = tag_r;
  assign out_ep    = ep_r;
  assign out_rem   = rem_r;
  assign out_q     = q_r;

endmodule

/* rtl/core/jimw_sqrt_cell.sv */
module jimw_sqrt_cell
  import jimw_pkg::*;
#(
  parameter int J = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  tag_t        in_tag,
  input  logic [31:0] in_v,
  input  logic [31:0] in_r,
  output logic        out_valid,
  output tag_t        out_tag,
  output logic [31:0] out_v,
  output logic [31:0] out_r
);

  logic [32:0] one_bit;
  logic [32:0] sum;
  logic        ge;
  logic [31:0] v_nxt;
  logic [31:0] r_nxt;
  logic [32:0] r_up;
  logic        valid_r;
  tag_t        tag_r;
  logic [31:0] v_r;
  logic [31:0] r_r;

  always_comb begin
    one_bit = 33'(1) << (2 * J);
    sum     = {1'b0, in_r} + one_bit;
    ge      = {1'b0, in_v} >= sum;
    r_up    = {2'b0, in_r[31:1]} + one_bit;
    v_nxt   = ge ? (in_v - sum[31:0]) : in_v;
    r_nxt   = ge ? r_up[31:0] : {1'b0, in_r[31:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    tag_r <= in_tag;
    v_r   <= v_nxt;
    r_r   <= r_nxt;
  end

  assign out_valid = valid_r;
  assign out_tag   = tag_r;
  assign out_v     = v_r;
  assign out_r     = r_r;

endmodule

/* rtl/core/jet_invariant_mass_window.sv */
// throughput: one word per cycle, busy is never raised
// pipeline: 14 exp cells, 21 divider cells, 5 momentum stages, 16 sqrt cells, 1 output stage
// reset clears all valid bits and loads the window bounds 400 and 560
// out_valid is a one-cycle strobe, the receiver cannot stall
module jet_invariant_mass_window
  import jimw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic        [15:0] in_trans_momentum,
  input  logic signed [13:0] in_pseudorapidity,
  input  logic signed [12:0] in_azimuth,
  input  logic        [15:0] in_jet_energy,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [15:0] cfg_wdata,
  output logic               out_valid,
  output logic        [15:0] out_jet_mass,
  output logic               out_mass_positive,
  output logic               out_in_window,
  output logic               out_saturated
);

  logic [15:0] win_low_r;
  logic [15:0] win_high_r;

  logic        ev [0:EXP_CELLS];
  tag_t        et [0:EXP_CELLS];
  logic [13:0] em [0:EXP_CELLS];
  logic [31:0] ea [0:EXP_CELLS];

  logic        dv [0:DIV_CELLS];
  tag_t        dt [0:DIV_CELLS];
  logic [31:0] de [0:DIV_CELLS];
  logic [41:0] dr [0:DIV_CELLS];
  logic [20:0] dq [0:DIV_CELLS];

  logic        sv [0:SQRT_CELLS];
  tag_t        st [0:SQRT_CELLS];
  logic [31:0] sx [0:SQRT_CELLS];
  logic [31:0] sr [0:SQRT_CELLS];

  logic        a_valid_r, b_valid_r, c_valid_r, d_valid_r, e_valid_r;
  tag_t        a_tag_r, b_tag_r, c_tag_r, d_tag_r, e_tag_r;
  logic [31:0] ch_r;
  logic [32:0] ch_sum;
  logic [47:0] prod_r;
  logic [48:0] prod_rnd;
  logic [15:0] p_r;
  logic        sat_nxt;
  logic [15:0] p_nxt;
  logic [31:0] e2_r, e2d_r;
  logic [31:0] p2_r;
  logic [31:0] diff_r;

  logic [16:0] root;
  logic [15:0] mass;

  logic        out_valid_r;
  logic [15:0] mass_r;
  logic        pos_r, win_r, sat_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r  <= WINDOW_LOW_RST;
      win_high_r <= WINDOW_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LOW:  win_low_r  <= cfg_wdata;
        REG_WINDOW_HIGH: win_high_r <= cfg_wdata;
      endcase
    end
  end

  // entry: |eta| and unit accumulator
  always_comb begin
    ev[0]        = start & ~busy;
    et[0].pt     = in_trans_momentum;
    et[0].energy = in_jet_energy;
    et[0].sat    = 1'b0;
    et[0].pos    = 1'b0;
    em[0]        = in_pseudorapidity[13] ? 14'(-in_pseudorapidity) : in_pseudorapidity;
    ea[0]        = Q_ONE;
  end

  for (genvar k = 0; k < EXP_CELLS; k++) begin : g_exp
    jimw_exp_cell #(.K(k)) u_cell (
      .clk, .rst_n,
      .in_valid(ev[k]), .in_tag(et[k]), .in_mag(em[k]), .in_acc(ea[k]),
      .out_valid(ev[k+1]), .out_tag(et[k+1]), .out_mag(em[k+1]), .out_acc(ea[k+1])
    );
  end

  // e^-|eta| = round(2^40 / e^|eta|)
  always_comb begin
    dv[0] = ev[EXP_CELLS];
    dt[0] = et[EXP_CELLS];
    de[0] = ea[EXP_CELLS];
    dr[0] = (42'(1) << 40) + 42'(ea[EXP_CELLS][31:1]);
    dq[0] = '0;
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    jimw_div_cell #(.I(DIV_CELLS - 1 - i)) u_cell (
      .clk, .rst_n,
      .in_valid(dv[i]), .in_tag(dt[i]), .in_ep(de[i]), .in_rem(dr[i]), .in_q(dq[i]),
      .out_valid(dv[i+1]), .out_tag(dt[i+1]), .out_ep(de[i+1]), .out_rem(dr[i+1]),
      .out_q(dq[i+1])
    );
  end

  always_comb begin
    ch_sum   = 33'(de[DIV_CELLS]) + 33'(dq[DIV_CELLS]) + 33'd1;
    prod_rnd = 49'(prod_r) + 49'(Q_HALF);
    if (prod_rnd[48:36] != '0) begin
      p_nxt   = 16'hFFFF;
      sat_nxt = 1'b1;
    end else begin
      p_nxt   = prod_rnd[35:20];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else begin
      a_valid_r <= dv[DIV_CELLS];
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
    end
    a_tag_r <= dt[DIV_CELLS];
    ch_r    <= ch_sum[32:1];
    b_tag_r <= a_tag_r;
    prod_r  <= 48'(a_tag_r.pt) * 48'(ch_r);
    c_tag_r <= {b_tag_r.pt, b_tag_r.energy, sat_nxt, b_tag_r.pos};
    p_r     <= p_nxt;
    e2_r    <= 32'(b_tag_r.energy) * 32'(b_tag_r.energy);
    d_tag_r <= c_tag_r;
    p2_r    <= 32'(p_r) * 32'(p_r);
    e2d_r   <= e2_r;
    e_tag_r <= {d_tag_r.pt, d_tag_r.energy, d_tag_r.sat, e2d_r > p2_r};
    diff_r  <= e2d_r - p2_r;
  end

  always_comb begin
    sv[0] = e_valid_r;
    st[0] = e_tag_r;
    sx[0] = diff_r;
    sr[0] = '0;
  end

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
    jimw_sqrt_cell #(.J(SQRT_CELLS - 1 - j)) u_cell (
      .clk, .rst_n,
      .in_valid(sv[j]), .in_tag(st[j]), .in_v(sx[j]), .in_r(sr[j]),
      .out_valid(sv[j+1]), .out_tag(st[j+1]), .out_v(sx[j+1]), .out_r(sr[j+1])
    );
  end

  // round to nearest, clamp, zero when not positive
  always_comb begin
    root = sr[SQRT_CELLS][16:0] + 17'(sx[SQRT_CELLS] > sr[SQRT_CELLS]);
    if (!st[SQRT_CELLS].pos) begin
      mass = '0;
    end else if (root[16]) begin
      mass = 16'hFFFF;
    end else begin
      mass = root[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sv[SQRT_CELLS];
    end
    mass_r <= mass;
    pos_r  <= st[SQRT_CELLS].pos;
    sat_r  <= st[SQRT_CELLS].sat;
    win_r  <= (mass >= win_low_r) && (mass <= win_high_r);
  end

  assign out_valid         = out_valid_r;
  assign out_jet_mass      = mass_r;
  assign out_mass_positive = pos_r;
  assign out_in_window     = win_r;
  assign out_saturated     = sat_r;

endmodule
